### rtl/bmsom_pkg.sv
// Shared types and constants of the binned median / sigma outlier mask.
// No dependencies; used by the top level, its checker and the bench.
package bmsom_pkg;

    localparam int VAL_W  = 32;
    localparam int BIN_W  = 10;
    localparam int IDX_W  = 16;
    localparam int NB_W   = 11;
    localparam int CFG_W  = 16;
    localparam int CFG_AW = 2;

    // Input tdata layout, lowest bit first.
    localparam int IN_TD_W     = 64;
    localparam int VAL_LSB     = 0;
    localparam int BMASK_BIT   = 32;
    localparam int BIN_LSB     = 33;
    localparam int PIX_IDX_LSB = 43;

    // Output tdata layout, lowest bit first.
    localparam int OUT_TD_W   = 24;
    localparam int MASKED_BIT = 16;

    localparam logic [CFG_AW-1:0] REG_NUM_BINS  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_STDEV_MUL = 2'd1;
    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 2'd2;

    localparam logic [NB_W-1:0]  NUM_BINS_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] STDEV_MUL_RST = 16'd768;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd0;

    localparam logic [4:0] TOP_BIT = 5'd30;

    typedef enum logic [4:0] {
        PASS_STATS  = 5'b00001,
        PASS_COUNT  = 5'b00010,
        PASS_DECIDE = 5'b00100,
        PASS_DEV    = 5'b01000,
        PASS_MASK   = 5'b10000
    } pass_t;

    typedef struct packed {
        logic             msk;
        logic [BIN_W-1:0] bin;
        logic [VAL_W-1:0] val;
    } pix_word_t;

endpackage

### rtl/binned_median_sigma_outlier_mask.sv
// Top level of the binned median / sigma outlier mask.
// Depends on bmsom_pkg (types, field layout, register indexes).
//
// Usage:
//   Slave stream: tuser = mode (0 load a pixel, 1 read a mask bit back),
//   tlast = last pixel of the image, tdata = value, base mask, bin, index.
//   Master stream: one beat per read-back beat: pixel index and mask bit.
//   Loads are taken one per cycle into the pixel memory while idle. The beat
//   with tlast set starts the computation, during which tready stays low:
//     bin memory clear     every bin record zeroed
//     stats pass           count, sum and sum of squares per bin
//     31 rank passes       a count pass over the pixels, each followed by a
//                          decide sweep over the bins
//     deviation sweep      serial multiply, square root, divide per non-empty bin
//     mask pass            compare each clipped pixel against its bin
//   In the pixel loops each clipped pixel reads the pixel memory, then its
//   bin record, then writes the record (the mask pass: the pixel) back before
//   the next pixel goes, so same-bin neighbors never overlap.
//   A read-back passes the pixel memory read register, then the output
//   register, where it waits while the receiver stalls; loads keep flowing.
//   Reset empties the image and restores the register defaults; memories are
//   not cleared (unloaded pixels read back as unmasked).
module binned_median_sigma_outlier_mask #(
    parameter int MAX_PIXELS = 65536,
    parameter int MAX_BINS   = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: pixel_value[31:0], base_mask[32], bin_index[42:33],
    //        pixel_index[58:43], zero fill
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bmsom_pkg::IN_TD_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tlast,
    // tuser: mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: read_index[15:0], masked[16], zero fill
    output logic [bmsom_pkg::OUT_TD_W-1:0]      m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [bmsom_pkg::CFG_AW-1:0]        cfg_index,
    input  logic [bmsom_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int PAW = $clog2(MAX_PIXELS);
    localparam int PCW = $clog2(MAX_PIXELS + 1);
    localparam int BAW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BCW = $clog2(MAX_BINS + 1);
    localparam int S1W = 31 + PCW;
    localparam int S2W = 62 + PCW;

    typedef struct packed {
        logic [PCW-1:0] cnt;
        logic [S1W-1:0] s1;
        logic [S2W-1:0] s2;
        logic [30:0]    pfx1;
        logic [30:0]    pfx2;
        logic [PCW-1:0] rk1;
        logic [PCW-1:0] rk2;
        logic [PCW-1:0] c1;
        logic [PCW-1:0] c2;
        logic [31:0]    dev;
    } bin_rec_t;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_READ    = 13'b0000000000010,
        ST_CLR     = 13'b0000000000100,
        ST_PX_RD   = 13'b0000000001000,
        ST_PX_BIN  = 13'b0000000010000,
        ST_PX_MUL  = 13'b0000000100000,
        ST_PX_WB   = 13'b0000001000000,
        ST_BN_RD   = 13'b0000010000000,
        ST_BN_DATA = 13'b0000100000000,
        ST_MUL1    = 13'b0001000000000,
        ST_MUL2    = 13'b0010000000000,
        ST_SQRT    = 13'b0100000000000,
        ST_DIV     = 13'b1000000000000
    } state_t;

    // Memories
    bmsom_pkg::pix_word_t pix_mem [MAX_PIXELS];
    bin_rec_t             bin_mem [MAX_BINS];

    bmsom_pkg::pix_word_t pm_rdata_reg, pm_wdata;
    logic [PAW-1:0]       pm_waddr, pm_raddr;
    logic                 pm_we, pm_re;
    bin_rec_t             bm_rdata_reg, bm_wdata;
    logic [BAW-1:0]       bm_waddr, bm_raddr;
    logic                 bm_we, bm_re;

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pix_mem[pm_waddr] <= pm_wdata;
        end
        if (pm_re)
        begin
            pm_rdata_reg <= pix_mem[pm_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bin_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata_reg <= bin_mem[bm_raddr];
        end
    end

    // Registers
    state_t                      state_reg, state_next;
    bmsom_pkg::pass_t            pass_reg, pass_next;
    logic [4:0]                  bit_reg, bit_next;
    logic [PCW-1:0]              px_reg, px_next;
    logic [BCW-1:0]              bin_ctr_reg, bin_ctr_next;
    logic [PCW-1:0]              load_count_reg, load_count_next;
    logic                        done_reg, done_next;
    logic [bmsom_pkg::NB_W-1:0]  num_bins_reg, num_bins_next;
    logic [bmsom_pkg::CFG_W-1:0] mult_reg, mult_next;
    logic [bmsom_pkg::CFG_W-1:0] thr_reg, thr_next;
    logic                        out_valid_reg, out_valid_next;
    logic [bmsom_pkg::IDX_W-1:0] out_idx_reg, out_idx_next;
    logic                        out_mask_reg, out_mask_next;
    logic                        rd_hit_reg, rd_hit_next;
    logic [63:0]                 mul_reg, mul_next;
    logic [127:0]                acc_reg, acc_next;
    logic [127:0]                ma_reg, ma_next;
    logic [S1W-1:0]              mb_reg, mb_next;
    logic [6:0]                  step_reg, step_next;
    logic [127:0]                p1_reg, p1_next;
    logic [127:0]                x_reg, x_next;
    logic [67:0]                 rem_reg, rem_next;
    logic [63:0]                 root_reg, root_next;
    logic [PCW-1:0]              div_r_reg, div_r_next;

    // Input fields
    logic [31:0]             in_val;
    logic                    in_bmask;
    logic [9:0]              in_bin;
    logic [15:0]             in_idx;
    logic                    in_accept;

    assign in_val   = s_axis_tdata[bmsom_pkg::VAL_LSB +: bmsom_pkg::VAL_W];
    assign in_bmask = s_axis_tdata[bmsom_pkg::BMASK_BIT];
    assign in_bin   = s_axis_tdata[bmsom_pkg::BIN_LSB +: bmsom_pkg::BIN_W];
    assign in_idx   = s_axis_tdata[bmsom_pkg::PIX_IDX_LSB +: bmsom_pkg::IDX_W];

    // Loads never wait on the output side; a read-back needs a free slot.
    assign s_axis_tready = (state_reg == ST_IDLE) &&
                           (!s_axis_tuser || !out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_mask_reg, out_idx_reg};

    // Datapath helpers
    bmsom_pkg::pix_word_t pix;
    bin_rec_t             rec;
    logic                 in_clip;
    logic [31:0]          hmask;
    logic                 match1, match2;
    logic [PCW-1:0]       rk1_cur, rk2_cur;
    logic [30:0]          bit_one;
    logic [31:0]          m2;
    logic                 over1, over2;
    logic [127:0]         acc_step;
    logic [67:0]          rem_sh;
    logic                 sq_ge;
    logic [PCW:0]         r_sh;
    logic                 dv_ge;
    logic [PCW-1:0]       ld_ptr;

    assign pix     = pm_rdata_reg;
    assign rec     = bm_rdata_reg;
    assign in_clip = !pix.msk && ({1'b0, pix.bin} < num_bins_reg) &&
                     (32'(pix.bin) < 32'(MAX_BINS));
    // Bits above the current rank bit must agree with the prefix found so far.
    assign hmask   = ~((32'd2 << bit_reg) - 32'd1);
    assign match1  = (((pix.val ^ {1'b0, rec.pfx1}) & hmask) == 32'd0) &&
                     !pix.val[bit_reg];
    assign match2  = (((pix.val ^ {1'b0, rec.pfx2}) & hmask) == 32'd0) &&
                     !pix.val[bit_reg];
    assign rk1_cur = (bit_reg == bmsom_pkg::TOP_BIT) ? ((rec.cnt - PCW'(1)) >> 1) :
                     rec.rk1;
    assign rk2_cur = (bit_reg == bmsom_pkg::TOP_BIT) ? (rec.cnt >> 1) : rec.rk2;
    assign bit_one = 31'(32'd1 << bit_reg);
    // Doubled median: sum of the two middle values (same value for odd counts).
    assign m2      = {1'b0, rec.pfx1} + {1'b0, rec.pfx2};
    assign over1   = (64'(pix.val) << 9) > ((64'(m2) << 8) + (mul_reg << 1));
    assign over2   = (64'(pix.val) << 1) >
                     (64'(m2) + (64'(rec.dev) << 1) + (64'(thr_reg) << 9));
    assign acc_step = acc_reg + (mb_reg[0] ? ma_reg : 128'd0);
    assign rem_sh   = {rem_reg[65:0], x_reg[127:126]};
    assign sq_ge    = rem_sh >= {2'b00, root_reg, 2'b01};
    assign r_sh     = {div_r_reg, root_reg[63]};
    assign dv_ge    = r_sh >= {1'b0, rec.cnt};
    assign ld_ptr   = done_reg ? '0 : load_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        bit_next        = bit_reg;
        px_next         = px_reg;
        bin_ctr_next    = bin_ctr_reg;
        load_count_next = load_count_reg;
        done_next       = done_reg;
        num_bins_next   = num_bins_reg;
        mult_next       = mult_reg;
        thr_next        = thr_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_idx_next    = out_idx_reg;
        out_mask_next   = out_mask_reg;
        rd_hit_next     = rd_hit_reg;
        mul_next        = mul_reg;
        acc_next        = acc_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        step_next       = step_reg;
        p1_next         = p1_reg;
        x_next          = x_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        div_r_next      = div_r_reg;

        pm_we    = 1'b0;
        pm_waddr = PAW'(px_reg);
        pm_wdata = pix;
        pm_re    = 1'b0;
        pm_raddr = PAW'(px_reg);
        bm_we    = 1'b0;
        bm_waddr = BAW'(bin_ctr_reg);
        bm_wdata = rec;
        bm_re    = 1'b0;
        bm_raddr = BAW'(bin_ctr_reg);

        if (cfg_we)
        begin
            unique case (cfg_index)
                bmsom_pkg::REG_NUM_BINS:  num_bins_next = cfg_wdata[bmsom_pkg::NB_W-1:0];
                bmsom_pkg::REG_STDEV_MUL: mult_next = cfg_wdata;
                bmsom_pkg::REG_THRESHOLD: thr_next = cfg_wdata;
                default:                  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !s_axis_tuser)
                begin
                    done_next       = 1'b0;
                    load_count_next = ld_ptr;
                    if (32'(ld_ptr) < 32'(MAX_PIXELS))
                    begin
                        pm_we           = 1'b1;
                        pm_waddr        = PAW'(ld_ptr);
                        pm_wdata.msk    = in_bmask | in_val[31];
                        pm_wdata.bin    = in_bin;
                        pm_wdata.val    = in_val;
                        load_count_next = ld_ptr + PCW'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        bin_ctr_next = '0;
                        state_next   = ST_CLR;
                    end
                end
                else if (in_accept)
                begin
                    out_idx_next = in_idx;
                    rd_hit_next  = 32'(in_idx) < 32'(load_count_reg);
                    pm_re        = 1'b1;
                    pm_raddr     = PAW'(in_idx);
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_mask_next  = rd_hit_reg & pix.msk;
                state_next     = ST_IDLE;
            end
            ST_CLR:
            begin
                bm_we    = 1'b1;
                bm_wdata = '0;
                if (bin_ctr_reg == BCW'(MAX_BINS - 1))
                begin
                    pass_next  = bmsom_pkg::PASS_STATS;
                    px_next    = '0;
                    state_next = ST_PX_RD;
                end
                else
                begin
                    bin_ctr_next = bin_ctr_reg + BCW'(1);
                end
            end
            ST_PX_RD:
            begin
                if (px_reg == load_count_reg)
                begin
                    priority case (pass_reg)
                        bmsom_pkg::PASS_STATS:
                        begin
                            bit_next   = bmsom_pkg::TOP_BIT;
                            pass_next  = bmsom_pkg::PASS_COUNT;
                            px_next    = '0;
                        end
                        bmsom_pkg::PASS_COUNT:
                        begin
                            pass_next    = bmsom_pkg::PASS_DECIDE;
                            bin_ctr_next = '0;
                            state_next   = ST_BN_RD;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else
                begin
                    pm_re      = 1'b1;
                    state_next = ST_PX_BIN;
                end
            end
            ST_PX_BIN:
            begin
                if (in_clip)
                begin
                    bm_re      = 1'b1;
                    bm_raddr   = BAW'(pix.bin);
                    state_next = ST_PX_MUL;
                end
                else
                begin
                    px_next    = px_reg + PCW'(1);
                    state_next = ST_PX_RD;
                end
            end
            ST_PX_MUL:
            begin
                // Square for the stats pass, deviation times multiplier for the mask.
                if (pass_reg == bmsom_pkg::PASS_STATS)
                begin
                    mul_next = pix.val * pix.val;
                end
                else
                begin
                    mul_next = rec.dev * {16'd0, mult_reg};
                end
                state_next = ST_PX_WB;
            end
            ST_PX_WB:
            begin
                bm_waddr = BAW'(pix.bin);
                if (pass_reg == bmsom_pkg::PASS_STATS)
                begin
                    bm_we       = 1'b1;
                    bm_wdata.cnt = rec.cnt + PCW'(1);
                    bm_wdata.s1  = rec.s1 + S1W'(pix.val);
                    bm_wdata.s2  = rec.s2 + S2W'(mul_reg);
                end
                else if (pass_reg == bmsom_pkg::PASS_COUNT)
                begin
                    bm_we       = 1'b1;
                    bm_wdata.c1 = rec.c1 + PCW'(match1);
                    bm_wdata.c2 = rec.c2 + PCW'(match2);
                end
                else if (over1 || over2)
                begin
                    pm_we        = 1'b1;
                    pm_wdata.msk = 1'b1;
                end
                px_next    = px_reg + PCW'(1);
                state_next = ST_PX_RD;
            end
            ST_BN_RD:
            begin
                if (bin_ctr_reg == BCW'(MAX_BINS))
                begin
                    if (pass_reg == bmsom_pkg::PASS_DECIDE && bit_reg != 5'd0)
                    begin
                        bit_next   = bit_reg - 5'd1;
                        pass_next  = bmsom_pkg::PASS_COUNT;
                        px_next    = '0;
                        state_next = ST_PX_RD;
                    end
                    else if (pass_reg == bmsom_pkg::PASS_DECIDE)
                    begin
                        pass_next    = bmsom_pkg::PASS_DEV;
                        bin_ctr_next = '0;
                    end
                    else
                    begin
                        pass_next  = bmsom_pkg::PASS_MASK;
                        px_next    = '0;
                        state_next = ST_PX_RD;
                    end
                end
                else
                begin
                    bm_re      = 1'b1;
                    state_next = ST_BN_DATA;
                end
            end
            ST_BN_DATA:
            begin
                if (pass_reg == bmsom_pkg::PASS_DECIDE)
                begin
                    // Pick the next rank bit for both middle elements.
                    bm_we = 1'b1;
                    if (rk1_cur < rec.c1)
                    begin
                        bm_wdata.rk1 = rk1_cur;
                    end
                    else
                    begin
                        bm_wdata.pfx1 = rec.pfx1 | bit_one;
                        bm_wdata.rk1  = rk1_cur - rec.c1;
                    end
                    if (rk2_cur < rec.c2)
                    begin
                        bm_wdata.rk2 = rk2_cur;
                    end
                    else
                    begin
                        bm_wdata.pfx2 = rec.pfx2 | bit_one;
                        bm_wdata.rk2  = rk2_cur - rec.c2;
                    end
                    bm_wdata.c1  = '0;
                    bm_wdata.c2  = '0;
                    bin_ctr_next = bin_ctr_reg + BCW'(1);
                    state_next   = ST_BN_RD;
                end
                else if (rec.cnt == '0)
                begin
                    bin_ctr_next = bin_ctr_reg + BCW'(1);
                    state_next   = ST_BN_RD;
                end
                else
                begin
                    acc_next   = '0;
                    ma_next    = 128'(rec.s2);
                    mb_next    = S1W'(rec.cnt);
                    step_next  = 7'(PCW);
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                // n * S2, one multiplier bit a cycle.
                acc_next  = acc_step;
                ma_next   = ma_reg << 1;
                mb_next   = mb_reg >> 1;
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    p1_next    = acc_step;
                    acc_next   = '0;
                    ma_next    = 128'(rec.s1);
                    mb_next    = rec.s1;
                    step_next  = 7'(S1W);
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                // S1 squared, then the variance numerator.
                acc_next  = acc_step;
                ma_next   = ma_reg << 1;
                mb_next   = mb_reg >> 1;
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    x_next     = p1_reg - acc_step;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = 7'd64;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // One root bit a cycle, two radicand bits shifted in.
                rem_next  = sq_ge ? (rem_sh - {2'b00, root_reg, 2'b01}) : rem_sh;
                root_next = {root_reg[62:0], sq_ge};
                x_next    = x_reg << 2;
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    div_r_next = '0;
                    step_next  = 7'd64;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring divide of the root by the count; quotient shifts in.
                div_r_next = dv_ge ? PCW'(r_sh - {1'b0, rec.cnt}) : PCW'(r_sh);
                root_next  = {root_reg[62:0], dv_ge};
                step_next  = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    bm_we        = 1'b1;
                    bm_wdata.dev = {root_reg[30:0], dv_ge};
                    bin_ctr_next = bin_ctr_reg + BCW'(1);
                    state_next   = ST_BN_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= bmsom_pkg::PASS_STATS;
            bit_reg        <= '0;
            px_reg         <= '0;
            bin_ctr_reg    <= '0;
            load_count_reg <= '0;
            done_reg       <= 1'b0;
            num_bins_reg   <= bmsom_pkg::NUM_BINS_RST;
            mult_reg       <= bmsom_pkg::STDEV_MUL_RST;
            thr_reg        <= bmsom_pkg::THRESHOLD_RST;
            out_valid_reg  <= 1'b0;
            rd_hit_reg     <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            bit_reg        <= bit_next;
            px_reg         <= px_next;
            bin_ctr_reg    <= bin_ctr_next;
            load_count_reg <= load_count_next;
            done_reg       <= done_next;
            num_bins_reg   <= num_bins_next;
            mult_reg       <= mult_next;
            thr_reg        <= thr_next;
            out_valid_reg  <= out_valid_next;
            rd_hit_reg     <= rd_hit_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_mask_reg <= out_mask_next;
        mul_reg      <= mul_next;
        acc_reg      <= acc_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        p1_reg       <= p1_next;
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        div_r_reg    <= div_r_next;
    end

endmodule

### rtl/bmsom_checker.sv
// Port-level checker for the binned median / sigma outlier mask, with its bind.
// Depends on bmsom_pkg (field layout).
module bmsom_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [bmsom_pkg::IN_TD_W-1:0]   s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bmsom_pkg::OUT_TD_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input taken during a read-back");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser, 2))
        else $error("output beat without a read-back beat");

    a_out_echo: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            m_axis_tdata[bmsom_pkg::IDX_W-1:0] ==
            $past(s_axis_tdata[bmsom_pkg::PIX_IDX_LSB +: bmsom_pkg::IDX_W], 2))
        else $error("read index does not match the request");

endmodule

bind binned_median_sigma_outlier_mask bmsom_checker u_bmsom_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/tb_top.sv
// Self-checking bench for binned_median_sigma_outlier_mask: loads small images,
// reads back mask bits and checks them against an in-bench mask predictor.
// Depends on bmsom_pkg and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXP = 256;          // images stay small: compute is slow
    localparam int WATCHDOG_LIMIT = 400000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [bmsom_pkg::IN_TD_W-1:0]     s_axis_tdata = '0;
    logic                              s_axis_tlast = 1'b0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [bmsom_pkg::OUT_TD_W-1:0]    m_axis_tdata;
    logic                              cfg_we = 1'b0;
    logic [bmsom_pkg::CFG_AW-1:0]      cfg_index = '0;
    logic [bmsom_pkg::CFG_W-1:0]       cfg_wdata = '0;

    binned_median_sigma_outlier_mask DUT (.*);

    always #5 clk = ~clk;

    // Mask predictor state
    logic [bmsom_pkg::NB_W-1:0]   cur_num_bins;
    logic [bmsom_pkg::CFG_W-1:0]  cur_mul;
    logic [bmsom_pkg::CFG_W-1:0]  cur_thr;
    logic [bmsom_pkg::VAL_W-1:0]  img_val [MAXP];
    logic [bmsom_pkg::BIN_W-1:0]  img_bin [MAXP];
    logic                         img_msk [MAXP];
    int                           img_count;
    bit                           img_done;

    typedef struct packed {
        logic [bmsom_pkg::IDX_W-1:0] idx;
        logic                        masked;
    } readback_t;

    readback_t mask_reads_due[$];
    int  errors = 0;
    int  beats_sent = 0;
    bit  quiet = 1'b0;                  // no idling on either side while set
    int  idle_cycles = 0;

    // Exact integer square root over the 128-bit variance numerator.
    function automatic logic [63:0] isqrt128(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic bit clipped(int i);
        return !img_msk[i] && ({1'b0, img_bin[i]} < cur_num_bins);
    endfunction

    // Per-bin median and deviation, then mark outliers.
    function automatic void clip_image();
        logic [32:0]  med2 [1024];
        logic [31:0]  dev  [1024];
        bit           seen [1024];
        longint unsigned vals[$];
        logic [63:0]  s1;
        logic [127:0] s2;
        logic [127:0] num;
        logic [63:0]  p;
        logic [63:0]  lhs1, rhs1, lhs2, rhs2;
        int           cnt;
        for (int b = 0; b < 1024; b++)
            seen[b] = 1'b0;
        for (int i = 0; i < img_count; i++)
        begin
            if (clipped(i) && !seen[img_bin[i]])
            begin
                seen[img_bin[i]] = 1'b1;
                vals.delete();
                for (int j = 0; j < img_count; j++)
                    if (clipped(j) && img_bin[j] == img_bin[i])
                        vals.insert(vals.size(), img_val[j]);
                vals.sort();
                cnt = vals.size();
                s1 = '0;
                s2 = '0;
                foreach (vals[k])
                begin
                    s1 += vals[k];
                    s2 += {64'd0, vals[k]} * {64'd0, vals[k]};
                end
                if (cnt % 2)
                    med2[img_bin[i]] = 33'(2 * vals[cnt/2]);
                else
                    med2[img_bin[i]] = 33'(vals[cnt/2-1] + vals[cnt/2]);
                num = 128'(cnt) * s2 - {64'd0, s1} * {64'd0, s1};
                dev[img_bin[i]] = 32'(isqrt128(num) / 64'(cnt));
            end
        end
        for (int i = 0; i < img_count; i++)
        begin
            if (clipped(i))
            begin
                p    = 64'(img_val[i]);
                lhs1 = 512 * p;
                rhs1 = 256 * 64'(med2[img_bin[i]])
                     + 2 * 64'(dev[img_bin[i]]) * 64'(cur_mul);
                lhs2 = 2 * p;
                rhs2 = 64'(med2[img_bin[i]]) + 2 * 64'(dev[img_bin[i]])
                     + (64'(cur_thr) << 9);
                if (lhs1 > rhs1 || lhs2 > rhs2)
                    img_msk[i] = 1'b1;
            end
        end
    endfunction

    // Apply one accepted input beat to the predictor.
    function automatic void predict_beat(logic mode, logic [31:0] v, logic bm,
                                         logic [9:0] bin, logic [15:0] idx,
                                         logic lst);
        readback_t r;
        if (mode)
        begin
            r.idx = idx;
            r.masked = (idx < img_count) ? img_msk[idx] : 1'b0;
            mask_reads_due.insert(mask_reads_due.size(), r);
            return;
        end
        if (img_done)
        begin
            img_count = 0;
            img_done = 1'b0;
        end
        img_val[img_count] = v;
        img_bin[img_count] = bin;
        img_msk[img_count] = bm | v[31];
        img_count++;
        if (lst)
        begin
            clip_image();
            img_done = 1'b1;
        end
    endfunction

    // Drive one beat at the falling edge and hold it until accepted.
    task automatic send_beat(logic mode, logic [31:0] v, logic bm, logic [9:0] bin,
                             logic [15:0] idx, logic lst);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tlast  <= lst;
        s_axis_tdata  <= {5'd0, idx, bin, bm, v};
        do @(posedge clk); while (!s_axis_tready);
        predict_beat(mode, v, bm, bin, idx, lst);
        beats_sent++;
    endtask

    task automatic sender_gap();
        int n;
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return;
        n = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic load_pixel(logic [31:0] v, logic bm, logic [9:0] bin, logic lst);
        send_beat(1'b0, v, bm, bin, 16'($urandom), lst);
        sender_gap();
    endtask

    task automatic read_mask(logic [15:0] idx);
        send_beat(1'b1, $urandom, 1'($urandom), 10'($urandom), idx, 1'($urandom));
        sender_gap();
    endtask

    // Hold off until every read-back is in and the block is ready again.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (mask_reads_due.size() != 0) @(posedge clk);
        do @(posedge clk); while (!s_axis_tready);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [bmsom_pkg::CFG_AW-1:0] r,
                             logic [bmsom_pkg::CFG_W-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (r)
            bmsom_pkg::REG_NUM_BINS:  cur_num_bins = d[bmsom_pkg::NB_W-1:0];
            bmsom_pkg::REG_STDEV_MUL: cur_mul = d;
            bmsom_pkg::REG_THRESHOLD: cur_thr = d;
            default: ;
        endcase
    endtask

    task automatic set_config(int nb, int mul, int thr);
        drain();
        write_reg(bmsom_pkg::REG_NUM_BINS, bmsom_pkg::CFG_W'(nb));
        write_reg(bmsom_pkg::REG_STDEV_MUL, bmsom_pkg::CFG_W'(mul));
        write_reg(bmsom_pkg::REG_THRESHOLD, bmsom_pkg::CFG_W'(thr));
    endtask

    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(0, 99);
        if (k < 75) return 32'($urandom_range(25000, 26000));
        if (k < 88) return 32'($urandom_range(26000, 200000));
        if (k < 94) return $urandom & 32'h7FFF_FFFF;
        return $urandom | 32'h8000_0000;
    endfunction

    // One image: loads with reads mixed in, then reads of positions 0 to n + 2, one in eight at a random index.
    task automatic run_image(int n, int span);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                read_mask(16'($urandom_range(0, i + 2)));
            load_pixel(pick_value(), ($urandom_range(0, 9) == 0),
                       ($urandom_range(0, 15) == 0) ? 10'($urandom)
                                                    : 10'($urandom_range(0, span)),
                       i == n - 1);
        end
        for (int i = 0; i < n + 3; i++)
            read_mask(16'(($urandom_range(0, 7) == 0) ? $urandom : i));
    endtask

    task automatic test_extremes();
        load_pixel(32'h7FFF_FFFF, 1'b0, 10'd0, 1'b0);
        load_pixel(32'h0000_0000, 1'b0, 10'd0, 1'b0);
        load_pixel(32'h0000_0100, 1'b0, 10'd0, 1'b0);
        load_pixel(32'h8000_0000, 1'b0, 10'd1, 1'b0);   // negative: masked
        load_pixel(32'hFFFF_FFFF, 1'b1, 10'd1023, 1'b0);
        read_mask(16'd3);                                // read while loading
        load_pixel(32'h0000_0100, 1'b1, 10'd1023, 1'b0);
        load_pixel(32'h0000_0200, 1'b0, 10'd1023, 1'b0);
        load_pixel(32'h0000_0300, 1'b0, 10'd1023, 1'b1);
        for (int i = 0; i < 9; i++)
            read_mask(16'(i));
        read_mask(16'hFFFF);                             // beyond the image
    endtask

    task automatic test_restart_and_stray_last();
        // New image over a done one, with last on read-backs ignored.
        load_pixel(32'd1000, 1'b0, 10'd5, 1'b0);
        send_beat(1'b1, 32'd0, 1'b0, 10'd0, 16'd0, 1'b1);
        load_pixel(32'd1000, 1'b0, 10'd5, 1'b0);
        load_pixel(32'd1000, 1'b0, 10'd5, 1'b0);
        load_pixel(32'd90000, 1'b0, 10'd5, 1'b0);
        load_pixel(32'd1000, 1'b0, 10'd6, 1'b1);        // lone pixel in a bin
        for (int i = 0; i < 7; i++)
            read_mask(16'(i));
    endtask

    task automatic test_random_images();
        int imgs;
        imgs = 0;
        while (beats_sent < 450 && imgs < 10)
        begin
            quiet = (imgs % 4 == 3);
            case (imgs % 5)
                0: set_config(1, 0, 0);
                1: set_config(1024, 65535, 65535);
                2: set_config($urandom_range(1, 3), $urandom_range(0, 1024),
                              $urandom_range(0, 64));
                3: set_config($urandom_range(1, 1024), $urandom, $urandom);
                default: set_config(1024, 256, 4);
            endcase
            run_image($urandom_range(12, 24), $urandom_range(0, 3));
            imgs++;
        end
        quiet = 1'b0;
    endtask

    // Receiver: random stalls, mostly short.
    int stall_left = 0;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 39) == 0)
        begin
            stall_left <= $urandom_range(10, 80);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= quiet || ($urandom_range(0, 3) != 0);
        end
    end

    // Check each read-back beat against the oldest one due.
    readback_t due;
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (mask_reads_due.size() == 0)
            begin
                $display("%0t: unexpected read-back beat, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                due = mask_reads_due.pop_front();
                if (m_axis_tdata[bmsom_pkg::IDX_W-1:0] !== due.idx)
                begin
                    $display("%0t: read_index expected %h actual %h", $time,
                             due.idx, m_axis_tdata[bmsom_pkg::IDX_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[bmsom_pkg::MASKED_BIT] !== due.masked)
                begin
                    $display("%0t: masked expected %b actual %b (index %h)", $time,
                             due.masked, m_axis_tdata[bmsom_pkg::MASKED_BIT], due.idx);
                    errors++;
                end
            end
        end
    end

    // Watchdog: the clipping pass is long, so allow a wide quiet window.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        cur_num_bins = bmsom_pkg::NUM_BINS_RST;
        cur_mul      = bmsom_pkg::STDEV_MUL_RST;
        cur_thr      = bmsom_pkg::THRESHOLD_RST;
        img_count    = 0;
        img_done     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();                     // reset register values
        set_config(2, 0, 0);
        test_restart_and_stray_last();
        set_config(1024, 768, 1);
        test_random_images();
        drain();
        repeat (20) @(posedge clk);
        if (mask_reads_due.size() != 0)
        begin
            $display("%0t: %0d read-backs never arrived", $time,
                     mask_reads_due.size());
            errors++;
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
